[design/cache_line_flush_table_defines.svh]
// Assertion macros for the flush table RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef CACHE_LINE_FLUSH_TABLE_DEFINES_SVH
`define CACHE_LINE_FLUSH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CLFT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("clft assertion failed");
`define CLFT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("clft assertion failed");
`else
`define CLFT_ASSERT_IMP(lbl, a, c)
`define CLFT_ASSERT_NXT(lbl, a, c)
`endif
`endif

[design/clft_pkg.sv]
`default_nettype none
package clft_pkg;

  localparam int ADDR_BITS     = 48;
  localparam int SIZE_BITS     = 12;
  localparam int CMD_BITS      = 2;
  localparam int TABLE_ENTRIES = 64;
  localparam int INDEX_SHIFT   = 6;
  localparam int LINE_BYTES    = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int SIZE_BOUND    = 4032;
  localparam int QUEUE_DEPTH   = 2;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS    = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAX_RESULTS);
  localparam int SPAN_BITS   = SIZE_BITS + 1;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_BITS-1:0] CMD_RECORD = CMD_BITS'(0);
  localparam logic [CMD_BITS-1:0] CMD_RANGE  = CMD_BITS'(1);
  localparam logic [CMD_BITS-1:0] CMD_DRAIN  = CMD_BITS'(2);

  localparam logic [ADDR_BITS-1:0] LINE_MASK = ~ADDR_BITS'(LINE_BYTES - 1);

  // One classified request: a walk over lines_m1 + 1 lines or table entries.
  typedef struct packed {
    logic                 drain;
    logic [ADDR_BITS-1:0] line;
    logic [CNT_BITS-1:0]  lines_m1;
  } job_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

endpackage
`default_nettype wire

[design/clft_if.sv]
`default_nettype none
interface clft_req_if;
  logic                                valid;
  logic                                ready;
  logic [clft_pkg::CMD_BITS-1:0]       cmd;
  logic [clft_pkg::ADDR_BITS-1:0]      addr;
  logic [clft_pkg::SIZE_BITS-1:0]      size;
  logic                                in_persistent;

  modport source (output valid, cmd, addr, size, in_persistent, input ready);
  modport sink   (input valid, cmd, addr, size, in_persistent, output ready);
endinterface

interface clft_flush_if;
  logic                           valid;
  logic                           ready;
  logic [clft_pkg::ADDR_BITS-1:0] flush_addr;
  logic                           last;

  modport source (output valid, flush_addr, last, input ready);
  modport sink   (input valid, flush_addr, last, output ready);
endinterface
`default_nettype wire

[design/clft_ram.sv]
`default_nettype none
module clft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/clft_front.sv]
`default_nettype none
// Accepts requests, drops the ones that do nothing and turns the rest into
// line walks for the back part.
module clft_front (
  clft_req_if.sink              req,
  input  wire clft_pkg::qstat_t stat,
  output logic                  push,
  output clft_pkg::job_t        job
);

  logic                               accept;
  logic                               useful;
  logic [clft_pkg::SIZE_BITS-1:0]     size_sat;
  logic [clft_pkg::SPAN_BITS-1:0]     span;
  logic [clft_pkg::SPAN_BITS-1:0]     span_lines;
  logic [clft_pkg::CNT_BITS-1:0]      range_m1;

  assign req.ready = !stat.full;
  assign accept    = req.valid && req.ready;

  // The number of extra lines a range touches depends only on the offset
  // within the first line and the length.
  always_comb begin
    size_sat = (req.size > clft_pkg::SIZE_BITS'(clft_pkg::SIZE_BOUND)) ?
               clft_pkg::SIZE_BITS'(clft_pkg::SIZE_BOUND) : req.size;
    span = clft_pkg::SPAN_BITS'(req.addr[clft_pkg::OFFSET_BITS-1:0])
         + clft_pkg::SPAN_BITS'(size_sat) - clft_pkg::SPAN_BITS'(1);
    span_lines = span >> clft_pkg::OFFSET_BITS;
    if (span_lines > clft_pkg::SPAN_BITS'(clft_pkg::MAX_RESULTS - 1)) begin
      range_m1 = clft_pkg::CNT_BITS'(clft_pkg::MAX_RESULTS - 1);
    end else begin
      range_m1 = span_lines[clft_pkg::CNT_BITS-1:0];
    end
  end

  always_comb begin
    useful       = 1'b0;
    job.drain    = 1'b0;
    job.line     = req.addr & clft_pkg::LINE_MASK;
    job.lines_m1 = '0;
    case (req.cmd)
      clft_pkg::CMD_RECORD: begin
        useful = req.in_persistent;
      end
      clft_pkg::CMD_RANGE: begin
        useful       = req.in_persistent && (req.size != '0);
        job.lines_m1 = range_m1;
      end
      clft_pkg::CMD_DRAIN: begin
        useful       = 1'b1;
        job.drain    = 1'b1;
        job.line     = '0;
        job.lines_m1 = clft_pkg::CNT_BITS'(clft_pkg::TABLE_ENTRIES - 1);
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  assign push = accept && useful;

endmodule
`default_nettype wire

[design/clft_queue.sv]
`default_nettype none
module clft_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire clft_pkg::job_t   push_job,
  input  wire logic             pop,
  output clft_pkg::job_t        head,
  output clft_pkg::qstat_t      stat
);

  clft_pkg::job_t                  entries [clft_pkg::QUEUE_DEPTH];
  logic [clft_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [clft_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [clft_pkg::QCNT_BITS-1:0]  count;

  function automatic logic [clft_pkg::QPTR_BITS-1:0] bump(
    input logic [clft_pkg::QPTR_BITS-1:0] p
  );
    if (p == clft_pkg::QPTR_BITS'(clft_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + clft_pkg::QPTR_BITS'(1);
  endfunction

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == clft_pkg::QCNT_BITS'(clft_pkg::QUEUE_DEPTH));
  assign stat.avail = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + clft_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - clft_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

[design/clft_back.sv]
`default_nettype none
`include "cache_line_flush_table_defines.svh"
// Walks one job at a time over the table: read an entry, compare, replace,
// and hand displaced lines to the output. The newest flush is held back one
// step so the final one of a job can carry last.
module clft_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire clft_pkg::job_t   job,
  input  wire clft_pkg::qstat_t stat,
  output logic                  pop,
  clft_flush_if.source          flush
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                          state;
  logic                                drain;
  logic [clft_pkg::ADDR_BITS-1:0]      cur_line;
  logic [clft_pkg::IDX_BITS-1:0]       cur_idx;
  logic [clft_pkg::CNT_BITS-1:0]       remaining;
  logic [clft_pkg::TABLE_ENTRIES-1:0]  valid;
  logic                                hold_v;
  logic [clft_pkg::ADDR_BITS-1:0]      hold_addr;
  logic                                out_valid;
  logic [clft_pkg::ADDR_BITS-1:0]      out_addr;
  logic                                out_last;

  logic [clft_pkg::ADDR_BITS-1:0]      rd_data;
  logic [clft_pkg::ADDR_BITS-1:0]      old_line;
  logic [clft_pkg::ADDR_BITS-1:0]      line_next;
  logic                                differ;
  logic                                emit;
  logic                                out_free;
  logic                                go;
  logic                                ram_we;

  clft_ram #(
    .WIDTH(clft_pkg::ADDR_BITS),
    .DEPTH(clft_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_idx),
    .wdata(cur_line),
    .raddr(cur_idx),
    .rdata(rd_data)
  );

  // An entry whose valid bit is clear reads as the empty mark.
  assign old_line  = valid[cur_idx] ? rd_data : '0;
  assign differ    = (old_line != cur_line);
  assign emit      = differ && (old_line != '0);
  assign out_free  = !out_valid || flush.ready;
  assign go        = !(emit && hold_v && !out_free);
  assign ram_we    = (state == ST_CHECK) && go && differ && (cur_line != '0);
  assign pop       = (state == ST_IDLE) && stat.avail;
  assign line_next = cur_line + clft_pkg::ADDR_BITS'(clft_pkg::LINE_BYTES);

  assign flush.valid      = out_valid;
  assign flush.flush_addr = out_addr;
  assign flush.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (flush.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (stat.avail) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (go) begin
            if (differ) begin
              valid[cur_idx] <= (cur_line != '0);
            end
            if (emit) begin
              hold_v <= 1'b1;
              if (hold_v) begin
                out_valid <= 1'b1;
              end
            end
            if (remaining == '0) begin
              state <= (hold_v || emit) ? ST_FINISH : ST_IDLE;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            hold_v    <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk position and flush payloads.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        drain     <= job.drain;
        cur_line  <= job.line;
        remaining <= job.lines_m1;
        cur_idx   <= job.drain ? '0 :
                     job.line[clft_pkg::INDEX_SHIFT +: clft_pkg::IDX_BITS];
      end
      ST_CHECK: begin
        if (go) begin
          if (emit) begin
            hold_addr <= old_line;
            if (hold_v) begin
              out_addr <= hold_addr;
              out_last <= 1'b0;
            end
          end
          if (remaining != '0) begin
            remaining <= remaining - clft_pkg::CNT_BITS'(1);
            if (drain) begin
              cur_idx <= cur_idx + clft_pkg::IDX_BITS'(1);
            end else begin
              cur_line <= line_next & clft_pkg::LINE_MASK;
              cur_idx  <= line_next[clft_pkg::INDEX_SHIFT +: clft_pkg::IDX_BITS];
            end
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_addr <= hold_addr;
          out_last <= 1'b1;
        end
      end
      default: begin
        drain <= drain;
      end
    endcase
  end

  `CLFT_ASSERT_IMP(a_idle_no_hold, state == ST_IDLE, !hold_v)
  `CLFT_ASSERT_IMP(a_finish_has_hold, state == ST_FINISH, hold_v)
  `CLFT_ASSERT_NXT(a_write_sets_valid, ram_we, valid[$past(cur_idx)])
  `CLFT_ASSERT_NXT(a_finish_last, state == ST_FINISH && out_free, out_valid && out_last)

endmodule
`default_nettype wire

[design/cache_line_flush_table.sv]
// Direct-mapped table of written cache lines that still need a write-back.
// Requests arrive on the req channel (cmd, addr, size, in_persistent) and
// flushes leave on the flush channel (flush_addr, last); both move one beat
// when valid and ready are high at a rising edge of clk.
// cmd 0 records one line, cmd 1 records every line of a byte range (at most
// 64 lines), cmd 2 writes back every held line and empties the table. A line
// that is displaced from its entry comes out as a flush beat; last marks the
// final beat caused by one request. Requests that do nothing give no beat.
// The front part classifies requests into a two-entry job queue, so req is
// accepted whenever the queue has room, even while the back part works.
// The back part takes the next job in its idle state, then handles each
// line with a table read followed by a compare and replace, since the
// table memory has a registered read. The newest flush is held one step so
// last can be set. When flush is stalled the back part waits with the held
// beat; the queue keeps accepting until full. Reset (rst, synchronous)
// empties the table through per-entry valid bits, and clears the queue and
// outputs.
`default_nettype none
module cache_line_flush_table (
  input  wire logic     clk,
  input  wire logic     rst,
  clft_req_if.sink      req,
  clft_flush_if.source  flush
);

  logic              push;
  logic              pop;
  clft_pkg::job_t    front_job;
  clft_pkg::job_t    head_job;
  clft_pkg::qstat_t  stat;

  // Classification only; requests that cause nothing never reach the queue.
  clft_front u_front (
    .req (req),
    .stat(stat),
    .push(push),
    .job (front_job)
  );

  // Short job queue that decouples request intake from the table walk.
  clft_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(front_job),
    .pop     (pop),
    .head    (head_job),
    .stat    (stat)
  );

  // Table walker and flush output register.
  clft_back u_back (
    .clk  (clk),
    .rst  (rst),
    .job  (head_job),
    .stat (stat),
    .pop  (pop),
    .flush(flush)
  );

endmodule
`default_nettype wire

[bench/flush_table_checker.sv]
`timescale 1ns / 100ps
module flush_table_checker
  import clft_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  clft_req_if       req,
  clft_flush_if     flush,
  output int        mismatch_count,
  output int        beats_owed
);

  typedef struct packed {
    logic [ADDR_BITS-1:0] flush_addr;
    logic                 last;
  } flush_beat_t;

  // Shadow of the pending-line table; zero marks an empty entry.
  logic [ADDR_BITS-1:0] held_line [TABLE_ENTRIES];
  flush_beat_t          owed_flushes [$];
  flush_beat_t          request_flushes [$];
  int                   mismatches = 0;

  function automatic void hold_line(input logic [ADDR_BITS-1:0] line);
    int unsigned slot;
    flush_beat_t beat;
    slot = int'((line >> INDEX_SHIFT) % TABLE_ENTRIES);
    if (held_line[slot] != line) begin
      if (held_line[slot] != '0) begin
        beat.flush_addr = held_line[slot];
        beat.last       = 1'b0;
        request_flushes.push_back(beat);
      end
      held_line[slot] = line;
    end
  endfunction

  // Works out the flush beats that one accepted request must produce.
  function automatic void predict_flushes(input logic [CMD_BITS-1:0]  cmd,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic [SIZE_BITS-1:0] size,
                                          input logic                 persistent);
    logic [ADDR_BITS-1:0] line;
    logic [ADDR_BITS-1:0] end_line;
    logic [ADDR_BITS-1:0] span;
    logic [SIZE_BITS-1:0] length;
    int                   line_count;
    int                   k;
    request_flushes.delete();
    case (cmd)
      CMD_RECORD: begin
        if (persistent) hold_line(addr & LINE_MASK);
      end
      CMD_RANGE: begin
        if (persistent && size != '0) begin
          length     = (size > SIZE_BOUND) ? SIZE_BITS'(SIZE_BOUND) : size;
          line       = addr & LINE_MASK;
          end_line   = (addr + ADDR_BITS'(length) - ADDR_BITS'(1)) & LINE_MASK;
          span       = (end_line - line) >> OFFSET_BITS;
          line_count = (span >= MAX_RESULTS) ? MAX_RESULTS : int'(span) + 1;
          for (k = 0; k < line_count; k++) begin
            hold_line(line);
            line = (line + ADDR_BITS'(LINE_BYTES)) & LINE_MASK;
          end
        end
      end
      CMD_DRAIN: begin
        for (k = 0; k < TABLE_ENTRIES; k++) begin
          if (held_line[k] != '0) begin
            request_flushes.push_back({held_line[k], 1'b0});
            held_line[k] = '0;
          end
        end
      end
      default: begin
      end
    endcase
    if (request_flushes.size() > 0)
      request_flushes[request_flushes.size() - 1].last = 1'b1;
    foreach (request_flushes[i]) owed_flushes.push_back(request_flushes[i]);
  endfunction

  always @(posedge clk) begin
    flush_beat_t want;
    if (rst) begin
      foreach (held_line[i]) held_line[i] = '0;
      owed_flushes.delete();
    end else begin
      if (req.valid && req.ready)
        predict_flushes(req.cmd, req.addr, req.size, req.in_persistent);
      if (flush.valid && flush.ready) begin
        if (owed_flushes.size() == 0) begin
          mismatches++;
          $display("%0t: flush beat expected none, got flush_addr %h last %b",
                   $time, flush.flush_addr, flush.last);
        end else begin
          want = owed_flushes.pop_front();
          if (flush.flush_addr !== want.flush_addr) begin
            mismatches++;
            $display("%0t: flush_addr expected %h, got %h",
                     $time, want.flush_addr, flush.flush_addr);
          end
          if (flush.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b, got %b (flush_addr %h)",
                     $time, want.last, flush.last, flush.flush_addr);
          end
        end
      end
    end
    mismatch_count <= mismatches;
    beats_owed     <= owed_flushes.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
  import clft_pkg::*;

  // The fourth command code has no meaning in the block and must be ignored.
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = CMD_BITS'(3);

  // Address bits above the index field; a small pool of these values makes
  // random lines collide in the table, so evictions happen often.
  localparam int TAG_SHIFT = INDEX_SHIFT + IDX_BITS;
  localparam int TAG_BITS  = ADDR_BITS - TAG_SHIFT;

  localparam int RANDOM_ITEMS = 175;
  // The quiet tail after the last owed beat outlasts the walk of a drain or
  // of a 64-line range.
  localparam int TAIL_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst;

  clft_req_if   req ();
  clft_flush_if flush ();

  int mismatch_count;
  int beats_owed;
  int burst_left = 0;
  int unsigned cycle_count = 0;

  cache_line_flush_table dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .flush (flush)
  );

  // The checker sits beside the block, watches both channels, predicts the
  // flush beats from every accepted request and compares them in order.
  flush_table_checker flush_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .flush          (flush),
    .mismatch_count (mismatch_count),
    .beats_owed     (beats_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A run that hangs (a lost beat or a stuck handshake) ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The flush receiver runs through stretches of different behavior: always
  // ready, coin-flip ready, mostly stalled, and strict alternation. Each
  // stretch has a random length, so stalls land on every phase of a walk.
  initial begin
    int stall_mode;
    int stretch;
    flush.ready <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stretch    = $urandom_range(20, 120);
      repeat (stretch) begin
        @(posedge clk);
        case (stall_mode)
          0:       flush.ready <= 1'b1;
          1:       flush.ready <= ($urandom_range(0, 1) == 1);
          2:       flush.ready <= ($urandom_range(0, 7) == 0);
          default: flush.ready <= ~flush.ready;
        endcase
      end
    end
  end

  // Presents one request and holds it until the block takes the beat. The
  // sender works in bursts: when a burst runs out, valid usually drops for a
  // random gap and a new burst length is drawn. Some bursts are long, which
  // gives stretches with no sender idling at all. Valid is only lowered when
  // a gap follows, so it never drops and rises within one time step.
  task automatic send_request(input logic [CMD_BITS-1:0]  cmd,
                              input logic [ADDR_BITS-1:0] addr,
                              input logic [SIZE_BITS-1:0] size,
                              input logic                 persistent);
    int gap;
    req.cmd           <= cmd;
    req.addr          <= addr;
    req.size          <= size;
    req.in_persistent <= persistent;
    req.valid         <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [CMD_BITS-1:0]  cmd;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] size;
    logic                 persistent;
    logic [TAG_BITS-1:0]  line_tags [4];
    int                   roll;
    int                   useful;

    req.valid         <= 1'b0;
    req.cmd           <= CMD_RECORD;
    req.addr          <= '0;
    req.size          <= '0;
    req.in_persistent <= 1'b0;
    rst               <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Line 0x40 and line 0x1040 share entry 1; line 0x1000
    // and line zero share entry 0.
    send_request(CMD_RECORD, 48'h0000_0000_0040, '0, 1'b1);
    // Another byte of the same line: already held, nothing comes out.
    send_request(CMD_RECORD, 48'h0000_0000_007F, '0, 1'b1);
    // A different line in the same entry evicts 0x40.
    send_request(CMD_RECORD, 48'h0000_0000_1040, '0, 1'b1);
    // Outside the persistent region and a zero-length range do nothing.
    send_request(CMD_RECORD, 48'h0000_0000_2080, '0, 1'b0);
    send_request(CMD_RANGE,  48'h0000_0000_3000, '0, 1'b1);
    // Line zero equals the empty mark: it flushes 0x1000 and leaves the
    // entry empty, and a second time finds nothing to flush.
    send_request(CMD_RECORD, 48'h0000_0000_1000, '0, 1'b1);
    send_request(CMD_RECORD, 48'h0000_0000_0010, '0, 1'b1);
    send_request(CMD_RECORD, 48'h0000_0000_0000, '0, 1'b1);
    // A range that runs past the top of the address space wraps to zero.
    send_request(CMD_RANGE,  48'hFFFF_FFFF_FF90, 12'd256, 1'b1);
    // A full-size range starting at the last byte of a line touches 64 lines,
    // the most that one walk covers.
    send_request(CMD_RANGE,  48'h1234_5678_9A3F, 12'd4032, 1'b1);
    // Sizes above the bound saturate; this one also evicts the lines above.
    send_request(CMD_RANGE,  48'h1234_5678_AA00, 12'hFFF, 1'b1);
    send_request(CMD_RANGE,  48'h0000_0000_0000, 12'd1, 1'b1);
    send_request(CMD_RECORD, '1, '1, 1'b1);
    // The unused command is ignored whatever its fields say.
    send_request(CMD_UNUSED, '1, '1, 1'b1);
    // Drain a nearly full table, then drain an empty one.
    send_request(CMD_DRAIN,  '0, '0, 1'b0);
    send_request(CMD_DRAIN,  '1, '1, 1'b1);
    send_request(CMD_RANGE,  '1, 12'd64, 1'b1);
    send_request(CMD_RANGE,  48'h0000_0000_5000, 12'd100, 1'b0);
    send_request(CMD_RECORD, 48'hAAAA_AAAA_AAAA, 12'hAAA, 1'b1);
    send_request(CMD_RECORD, 48'h5555_5555_5555, 12'h555, 1'b1);
    send_request(CMD_DRAIN,  48'h5555_5555_5555, 12'h555, 1'b1);

    // Random part. Most addresses draw their upper bits from a small pool of
    // tags so that entries are hit, replaced and re-recorded; the rest sit
    // near the top or bottom of the address space or are fully random.
    line_tags[0] = '0;
    line_tags[1] = '1;
    line_tags[2] = TAG_BITS'({$urandom(), $urandom()});
    line_tags[3] = TAG_BITS'({$urandom(), $urandom()});
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0)
        line_tags[$urandom_range(2, 3)] = TAG_BITS'({$urandom(), $urandom()});

      roll = $urandom_range(0, 99);
      if (roll < 50)      cmd = CMD_RECORD;
      else if (roll < 85) cmd = CMD_RANGE;
      else if (roll < 93) cmd = CMD_DRAIN;
      else                cmd = CMD_UNUSED;

      roll = $urandom_range(0, 9);
      if (roll < 6)      addr = {line_tags[$urandom_range(0, 3)], TAG_SHIFT'($urandom())};
      else if (roll < 7) addr = ~ADDR_BITS'($urandom_range(0, 4095));
      else if (roll < 8) addr = ADDR_BITS'($urandom_range(0, 8191));
      else               addr = ADDR_BITS'({$urandom(), $urandom()});

      // Mostly short ranges, with a few long, saturated and empty ones.
      roll = $urandom_range(0, 19);
      if (roll == 0)      size = '0;
      else if (roll < 14) size = SIZE_BITS'($urandom_range(1, 256));
      else if (roll < 18) size = SIZE_BITS'($urandom_range(257, 4095));
      else                size = SIZE_BITS'($urandom_range(SIZE_BOUND, 4095));

      persistent = ($urandom_range(0, 9) != 0);

      send_request(cmd, addr, size, persistent);

      // Requests that the block is bound to ignore do not count.
      if (cmd == CMD_DRAIN ||
          (cmd == CMD_RECORD && persistent) ||
          (cmd == CMD_RANGE && persistent && size != '0))
        useful++;
    end

    // No beat is pending here in the same time step as the last handshake
    // unless a gap already lowered valid in an earlier step.
    req.valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && beats_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
